### src/ert_pkg.sv
// Shared types and constants of the epoch reclamation tracker.
// No dependencies; ert_if, the top level and ert_cmp refer to it by scoped names.
`default_nettype none

package ert_pkg;

  localparam int unsigned READERS      = 16;
  localparam int unsigned RETIRE_DEPTH = 32;
  localparam int unsigned HANDLE_BITS  = 32;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned READER_W = 4;
  localparam int unsigned EPOCH_W = 64;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned ADDR_W  = (RETIRE_DEPTH > 1) ? $clog2(RETIRE_DEPTH) : 1;
  localparam int unsigned SLOT_W  = (READERS > 1) ? $clog2(READERS) : 1;

  localparam logic [EPOCH_W-1:0] QUIESCENT = {EPOCH_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ENTER   = 3'd0,
    OP_EXIT    = 3'd1,
    OP_RETIRE  = 3'd2,
    OP_RECLAIM = 3'd3,
    OP_FORCE   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_MIN,
    ST_RD,
    ST_CHK,
    ST_LAST,
    ST_MOVE,
    ST_FIN,
    ST_FRD,
    ST_FEMIT
  } state_e;

  typedef struct packed {
    logic [EPOCH_W-1:0]     epoch;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                   freed_valid;
    logic [HANDLE_BITS-1:0] freed_handle;
    logic                   last;
    logic [CNT_W-1:0]       freed_count;
    logic [CNT_W-1:0]       pending_count;
    logic                   status;
  } result_t;

endpackage

`default_nettype wire

### src/ert_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on ert_pkg for field widths.
`default_nettype none

interface ert_req_if;
  logic                            valid;
  logic                            ready;
  logic [ert_pkg::OP_W-1:0]        op;
  logic [ert_pkg::READER_W-1:0]    reader;
  logic [ert_pkg::HANDLE_BITS-1:0] handle;

  modport source (output valid, op, reader, handle, input ready);
  modport sink   (input valid, op, reader, handle, output ready);
endinterface

interface ert_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            freed_valid;
  logic [ert_pkg::HANDLE_BITS-1:0] freed_handle;
  logic                            last;
  logic [ert_pkg::CNT_W-1:0]       freed_count;
  logic [ert_pkg::CNT_W-1:0]       pending_count;
  logic                            status;

  modport source (output valid, freed_valid, freed_handle, last, freed_count,
                  pending_count, status, input ready);
  modport sink   (input valid, freed_valid, freed_handle, last, freed_count,
                  pending_count, status, output ready);
endinterface

`default_nettype wire

### src/epoch_reclamation_tracker_unit.sv
// Epoch reclamation tracker: top level, sequencer and reader slot registers.
// Depends on ert_pkg, ert_if, ert_ram and ert_cmp.
//
// Usage: one request beat on req_i carries op, reader and handle. Enter and
// exit read set a reader slot, retire bumps the global epoch and appends the
// handle to the retire list (or sets status when full), reclaim frees every
// entry not newer than the oldest active reader, force reclaim frees the
// whole list. Each request yields one or more result beats on rsp_o; the
// final one has last set. A request is taken only while the sequencer is
// idle (req_i.ready). Enter, exit, retire and unknown ops give one result.
// Reclaim runs a min scan over the reader slots through the shared
// comparator, then walks the retire list through the RAM port: each entry
// is read and tested, and a freed entry is overwritten by the last entry of
// the list. Force reclaim reads and emits each entry in turn. The single
// RAM read port and the shared comparator set the pace.
// Results sit in an output register: a stalled receiver stalls the walk but
// a request can still be taken while the final result waits. Reset empties
// the list, zeroes the epoch and marks all reader slots quiescent.
`default_nettype none

module epoch_reclamation_tracker_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ert_req_if.sink    req_i,
  ert_rsp_if.source  rsp_o
);
  localparam int unsigned EW = ert_pkg::EPOCH_W;
  localparam int unsigned CW = ert_pkg::CNT_W;
  localparam int unsigned AW = ert_pkg::ADDR_W;
  localparam int unsigned SW = ert_pkg::SLOT_W;

  ert_pkg::state_e  state_q, state_d;
  logic [EW-1:0]    gepoch_q, gepoch_d;
  logic [EW-1:0]    reader_q [ert_pkg::READERS];
  logic [EW-1:0]    reader_d [ert_pkg::READERS];
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    nfreed_q, nfreed_d;
  logic [SW-1:0]    slot_q, slot_d;
  logic [EW-1:0]    min_q, min_d;
  ert_pkg::result_t res_q, res_d;
  ert_pkg::result_t held_q, held_d;
  logic             held_v_q, held_v_d;
  ert_pkg::result_t out_q, out_d;
  logic             out_v_q, out_v_d;

  logic             accept;
  logic             out_free;
  logic             push;
  ert_pkg::result_t push_res;

  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  ert_pkg::entry_t  ram_wdata, ram_rdata;

  logic [EW-1:0]    cmp_a, cmp_b;
  logic             cmp_le;
  logic             f_last;

  assign req_i.ready = (state_q == ert_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_v_q || rsp_o.ready;
  assign f_last      = ((idx_q + 1'b1) == count_q);

  ert_ram #(
    .WIDTH ($bits(ert_pkg::entry_t)),
    .DEPTH (ert_pkg::RETIRE_DEPTH)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cmp_a = (state_q == ert_pkg::ST_MIN) ? reader_q[slot_q] : ram_rdata.epoch;
  assign cmp_b = min_q;

  ert_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .le_o (cmp_le)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ert_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_i.op)
            ert_pkg::OP_RECLAIM: state_d = ert_pkg::ST_MIN;
            ert_pkg::OP_FORCE:   state_d = (count_q == '0) ? ert_pkg::ST_SINGLE
                                                           : ert_pkg::ST_FRD;
            default:             state_d = ert_pkg::ST_SINGLE;
          endcase
        end
      end
      ert_pkg::ST_SINGLE: if (out_free) state_d = ert_pkg::ST_IDLE;
      ert_pkg::ST_MIN: begin
        if (slot_q == SW'(ert_pkg::READERS - 1)) state_d = ert_pkg::ST_RD;
      end
      ert_pkg::ST_RD:   state_d = (idx_q < count_q) ? ert_pkg::ST_CHK : ert_pkg::ST_FIN;
      ert_pkg::ST_CHK: begin
        if (!cmp_le) begin
          state_d = ert_pkg::ST_RD;
        end else if (!held_v_q || out_free) begin
          state_d = ert_pkg::ST_LAST;
        end
      end
      ert_pkg::ST_LAST: state_d = ert_pkg::ST_MOVE;
      ert_pkg::ST_MOVE: state_d = ert_pkg::ST_RD;
      ert_pkg::ST_FIN:  if (out_free) state_d = ert_pkg::ST_IDLE;
      ert_pkg::ST_FRD:  state_d = ert_pkg::ST_FEMIT;
      ert_pkg::ST_FEMIT: begin
        if (out_free) state_d = f_last ? ert_pkg::ST_IDLE : ert_pkg::ST_FRD;
      end
      default: state_d = ert_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    gepoch_d  = gepoch_q;
    reader_d  = reader_q;
    count_d   = count_q;
    idx_d     = idx_q;
    nfreed_d  = nfreed_q;
    slot_d    = slot_q;
    min_d     = min_q;
    res_d     = res_q;
    held_d    = held_q;
    held_v_d  = held_v_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    push      = 1'b0;
    push_res  = res_q;

    case (state_q)
      ert_pkg::ST_IDLE: begin
        if (accept) begin
          res_d               = '0;
          res_d.last          = 1'b1;
          res_d.pending_count = count_q;
          idx_d               = '0;
          nfreed_d            = '0;
          slot_d              = '0;
          min_d               = ert_pkg::QUIESCENT;
          held_v_d            = 1'b0;
          case (req_i.op)
            ert_pkg::OP_ENTER, ert_pkg::OP_EXIT: begin
              if (32'(req_i.reader) < ert_pkg::READERS) begin
                reader_d[SW'(req_i.reader)] = (req_i.op == ert_pkg::OP_ENTER)
                                              ? gepoch_q : ert_pkg::QUIESCENT;
              end
            end
            ert_pkg::OP_RETIRE: begin
              gepoch_d = gepoch_q + 1'b1;
              if (32'(count_q) < ert_pkg::RETIRE_DEPTH) begin
                ram_we              = 1'b1;
                ram_waddr           = count_q[AW-1:0];
                ram_wdata.epoch     = gepoch_q + 1'b1;
                ram_wdata.handle    = req_i.handle;
                count_d             = count_q + 1'b1;
                res_d.pending_count = count_q + 1'b1;
              end else begin
                res_d.status = 1'b1;
              end
            end
            ert_pkg::OP_FORCE: res_d.pending_count = '0;
            default: ;
          endcase
        end
      end
      ert_pkg::ST_SINGLE: begin
        push     = 1'b1;
        push_res = res_q;
      end
      ert_pkg::ST_MIN: begin
        if (cmp_le) min_d = reader_q[slot_q];
        slot_d = slot_q + 1'b1;
      end
      ert_pkg::ST_RD: begin
        ram_re = 1'b1;
      end
      ert_pkg::ST_CHK: begin
        if (!cmp_le) begin
          idx_d = idx_q + 1'b1;
        end else if (!held_v_q || out_free) begin
          // previous freed beat is known not to be the final one
          push                = held_v_q;
          push_res            = held_q;
          held_d              = '0;
          held_d.freed_valid  = 1'b1;
          held_d.freed_handle = ram_rdata.handle;
          held_d.freed_count  = nfreed_q + 1'b1;
          held_d.pending_count = count_q - 1'b1;
          held_v_d            = 1'b1;
          nfreed_d            = nfreed_q + 1'b1;
          count_d             = count_q - 1'b1;
        end
      end
      ert_pkg::ST_LAST: begin
        // count already decremented: it now points at the old last entry
        ram_re    = 1'b1;
        ram_raddr = count_q[AW-1:0];
      end
      ert_pkg::ST_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q[AW-1:0];
        ram_wdata = ram_rdata;
      end
      ert_pkg::ST_FIN: begin
        push = 1'b1;
        if (held_v_q) begin
          push_res      = held_q;
          push_res.last = 1'b1;
        end else begin
          push_res               = '0;
          push_res.last          = 1'b1;
          push_res.pending_count = count_q;
        end
        if (out_free) held_v_d = 1'b0;
      end
      ert_pkg::ST_FRD: begin
        ram_re = 1'b1;
      end
      ert_pkg::ST_FEMIT: begin
        push                   = 1'b1;
        push_res               = '0;
        push_res.freed_valid   = 1'b1;
        push_res.freed_handle  = ram_rdata.handle;
        push_res.last          = f_last;
        push_res.freed_count   = idx_q + 1'b1;
        push_res.pending_count = count_q - (idx_q + 1'b1);
        if (out_free) begin
          idx_d = idx_q + 1'b1;
          if (f_last) count_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_d   = out_q;
    out_v_d = out_v_q;
    if (out_v_q && rsp_o.ready) out_v_d = 1'b0;
    if (push && out_free) begin
      out_d   = push_res;
      out_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ert_pkg::ST_IDLE;
      gepoch_q <= '0;
      count_q  <= '0;
      held_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < int'(ert_pkg::READERS); i++) begin
        reader_q[i] <= ert_pkg::QUIESCENT;
      end
    end else begin
      state_q  <= state_d;
      gepoch_q <= gepoch_d;
      count_q  <= count_d;
      held_v_q <= held_v_d;
      out_v_q  <= out_v_d;
      reader_q <= reader_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    nfreed_q <= nfreed_d;
    slot_q   <= slot_d;
    min_q    <= min_d;
    res_q    <= res_d;
    held_q   <= held_d;
    out_q    <= out_d;
  end

  assign rsp_o.valid         = out_v_q;
  assign rsp_o.freed_valid   = out_q.freed_valid;
  assign rsp_o.freed_handle  = out_q.freed_handle;
  assign rsp_o.last          = out_q.last;
  assign rsp_o.freed_count   = out_q.freed_count;
  assign rsp_o.pending_count = out_q.pending_count;
  assign rsp_o.status        = out_q.status;
endmodule

`default_nettype wire

### src/ert_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ert_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

`default_nettype wire

### src/ert_cmp.sv
// Shared 64-bit unsigned less-or-equal compare, used by the min scan
// and by the reclaim test. Depends on ert_pkg.
`default_nettype none

module ert_cmp (
  input  wire logic [ert_pkg::EPOCH_W-1:0] a_i,
  input  wire logic [ert_pkg::EPOCH_W-1:0] b_i,
  output logic                             le_o
);
  logic [ert_pkg::EPOCH_W:0] diff;

  // borrow out of b - a is set exactly when a > b
  assign diff = {1'b0, b_i} - {1'b0, a_i};
  assign le_o = ~diff[ert_pkg::EPOCH_W];
endmodule

`default_nettype wire
